// ----- sv/mrpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrpm_pkg
// Shared types, codes and the CRC16 byte step for the Modbus RTU poll master.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpm_pkg;

    localparam int unsigned C_ADDR_W = 5;

    localparam logic [15:0] C_CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] C_CRC_POLY      = 16'hA001;
    localparam logic [7:0]  C_FUNC_READ_REG = 8'h03;
    localparam int unsigned C_MIN_RESP      = 9;

    localparam logic [7:0]  C_ADDR0_RST     = 8'h01;
    localparam logic [7:0]  C_ADDR1_RST     = 8'h02;
    localparam logic [7:0]  C_ADDR2_RST     = 8'h50;
    localparam logic [15:0] C_START_RST     = 16'h0000;
    localparam logic [15:0] C_COUNT_RST     = 16'h0002;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_END   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_ADDR_MISS = 2'd2,
        ST_CRC_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_POLL_ADDR_0 = 3'd0,
        REG_POLL_ADDR_1 = 3'd1,
        REG_POLL_ADDR_2 = 3'd2,
        REG_START_REG   = 3'd3,
        REG_REG_COUNT   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        BYTE_ADDR     = 3'd0,
        BYTE_FUNC     = 3'd1,
        BYTE_START_HI = 3'd2,
        BYTE_START_LO = 3'd3,
        BYTE_COUNT_HI = 3'd4,
        BYTE_COUNT_LO = 3'd5,
        BYTE_CRC_LO   = 3'd6,
        BYTE_CRC_HI   = 3'd7
    } t_req_byte;

    localparam logic C_KIND_TX      = 1'b0;
    localparam logic C_KIND_OUTCOME = 1'b1;

    typedef logic [2:0][7:0] t_addr_arr;

    typedef struct packed {
        logic        is_start;
        logic [7:0]  addr;
        t_status     status;
        logic [1:0]  slave_idx;
        logic [15:0] reg_first;
        logic [15:0] reg_second;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mrpm_front.sv -----
// ----------------------------------------------------------------------------
// mrpm_front
// Accepts items, keeps the receive state and running CRC, and queues
// request and outcome commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpm_front #(
    parameter int unsigned RX_BUFFER_BYTES = 64,
    parameter int unsigned SLAVE_COUNT     = 3
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire [1:0]           i_op,
    input  wire [7:0]           i_rx_byte,
    input  mrpm_pkg::t_addr_arr i_poll_addr,
    input  wire                 i_cmd_full,
    output logic                o_cmd_push,
    output mrpm_pkg::t_cmd      o_cmd
);

    localparam int unsigned CW = $clog2(RX_BUFFER_BYTES + 1);

    logic [CW-1:0] r_rx_count, n_rx_count;
    logic [15:0]   r_crc, n_crc;
    logic [1:0]    r_cur_slave, n_cur_slave;
    logic [7:0]    r_first_byte;
    logic [7:0]    r_payload [4];
    logic [7:0]    r_recent [2];

    logic          accept;
    logic          rx_store;
    logic [1:0]    pay_idx;
    logic [7:0]    cur_addr;

    assign accept   = i_push & ~i_cmd_full;
    assign rx_store = accept && (i_op == mrpm_pkg::OP_RX) &&
                      (r_rx_count < CW'(RX_BUFFER_BYTES));
    assign pay_idx  = 2'(r_rx_count - CW'(3));

    always_comb begin
        case (r_cur_slave)
            2'd1:    cur_addr = i_poll_addr[1];
            2'd2:    cur_addr = i_poll_addr[2];
            default: cur_addr = i_poll_addr[0];
        endcase
    end

    always_comb begin
        n_rx_count  = r_rx_count;
        n_crc       = r_crc;
        n_cur_slave = r_cur_slave;
        o_cmd_push  = 1'b0;
        o_cmd       = '0;
        o_cmd.addr  = cur_addr;
        o_cmd.slave_idx = r_cur_slave;
        if (accept) begin
            unique case (i_op)
                mrpm_pkg::OP_START: begin
                    n_rx_count     = '0;
                    n_crc          = mrpm_pkg::C_CRC_INIT;
                    o_cmd_push     = 1'b1;
                    o_cmd.is_start = 1'b1;
                end
                mrpm_pkg::OP_RX: begin
                    if (rx_store) begin
                        if (r_rx_count >= CW'(2)) begin
                            n_crc = mrpm_pkg::crc_byte(r_crc, r_recent[0]);
                        end
                        n_rx_count = r_rx_count + CW'(1);
                    end
                end
                mrpm_pkg::OP_END: begin
                    o_cmd_push = 1'b1;
                    if (r_rx_count < CW'(mrpm_pkg::C_MIN_RESP)) begin
                        o_cmd.status = mrpm_pkg::ST_SHORT;
                    end else if (r_first_byte != cur_addr) begin
                        o_cmd.status = mrpm_pkg::ST_ADDR_MISS;
                    end else if ({r_recent[1], r_recent[0]} != r_crc) begin
                        o_cmd.status = mrpm_pkg::ST_CRC_MISS;
                    end else begin
                        o_cmd.status     = mrpm_pkg::ST_OK;
                        o_cmd.reg_first  = {r_payload[0], r_payload[1]};
                        o_cmd.reg_second = {r_payload[2], r_payload[3]};
                    end
                    if (r_cur_slave == 2'(SLAVE_COUNT - 1)) begin
                        n_cur_slave = '0;
                    end else begin
                        n_cur_slave = r_cur_slave + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count  <= '0;
            r_crc       <= mrpm_pkg::C_CRC_INIT;
            r_cur_slave <= '0;
        end else begin
            r_rx_count  <= n_rx_count;
            r_crc       <= n_crc;
            r_cur_slave <= n_cur_slave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_store) begin
            r_recent[0] <= r_recent[1];
            r_recent[1] <= i_rx_byte;
            if (r_rx_count == '0) begin
                r_first_byte <= i_rx_byte;
            end
            if ((r_rx_count >= CW'(3)) && (r_rx_count <= CW'(6))) begin
                r_payload[pay_idx] <= i_rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/mrpm_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// mrpm_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpm_cmd_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  mrpm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output mrpm_pkg::t_cmd o_cmd
);

    mrpm_pkg::t_cmd r_mem [4];
    logic [1:0]     r_wr_ptr, n_wr_ptr;
    logic [1:0]     r_rd_ptr, n_rd_ptr;
    logic [2:0]     r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_valid = (r_count != 3'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 2'd1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 2'd1 : r_rd_ptr;
        n_count  = r_count + {2'b00, do_push} - {2'b00, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mrpm_back.sv -----
// ----------------------------------------------------------------------------
// mrpm_back
// Expands queued commands into request bytes or an outcome, computing the
// request CRC a byte per cycle unless stalled, into a result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpm_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cmd_valid,
    input  mrpm_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  wire [15:0]     i_start_reg,
    input  wire [15:0]     i_reg_count,
    output logic           o_empty,
    input  wire            i_pop,
    output logic           o_kind,
    output logic [7:0]     o_tx_byte,
    output logic           o_last,
    output logic [1:0]     o_status,
    output logic [1:0]     o_slave_index,
    output logic [15:0]    o_reg_first,
    output logic [15:0]    o_reg_second
);

    logic        r_out_valid, n_out_valid;
    logic        r_kind;
    logic [7:0]  r_tx_byte;
    logic        r_last;
    logic [1:0]  r_status;
    logic [1:0]  r_slave_index;
    logic [15:0] r_reg_first;
    logic [15:0] r_reg_second;

    mrpm_pkg::t_req_byte r_idx, n_idx;
    logic [15:0] r_crc, n_crc;

    logic        slot_free;
    logic        emit;
    logic [15:0] crc_cur;
    logic [7:0]  req_byte;

    assign slot_free = ~r_out_valid | i_pop;
    assign emit      = i_cmd_valid & slot_free;
    assign crc_cur   = (r_idx == mrpm_pkg::BYTE_ADDR) ? mrpm_pkg::C_CRC_INIT : r_crc;

    always_comb begin
        unique case (r_idx)
            mrpm_pkg::BYTE_ADDR:     req_byte = i_cmd.addr;
            mrpm_pkg::BYTE_FUNC:     req_byte = mrpm_pkg::C_FUNC_READ_REG;
            mrpm_pkg::BYTE_START_HI: req_byte = i_start_reg[15:8];
            mrpm_pkg::BYTE_START_LO: req_byte = i_start_reg[7:0];
            mrpm_pkg::BYTE_COUNT_HI: req_byte = i_reg_count[15:8];
            mrpm_pkg::BYTE_COUNT_LO: req_byte = i_reg_count[7:0];
            mrpm_pkg::BYTE_CRC_LO:   req_byte = r_crc[7:0];
            mrpm_pkg::BYTE_CRC_HI:   req_byte = r_crc[15:8];
            default:                 req_byte = '0;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid & ~i_pop;
        o_cmd_pop   = 1'b0;
        if (emit) begin
            n_out_valid = 1'b1;
            if (i_cmd.is_start) begin
                n_idx = mrpm_pkg::t_req_byte'(r_idx + 3'd1);
                if (r_idx < mrpm_pkg::BYTE_CRC_LO) begin
                    n_crc = mrpm_pkg::crc_byte(crc_cur, req_byte);
                end
                if (r_idx == mrpm_pkg::BYTE_CRC_HI) begin
                    o_cmd_pop = 1'b1;
                end
            end else begin
                o_cmd_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= mrpm_pkg::BYTE_ADDR;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (emit) begin
            if (i_cmd.is_start) begin
                r_kind        <= mrpm_pkg::C_KIND_TX;
                r_tx_byte     <= req_byte;
                r_last        <= (r_idx == mrpm_pkg::BYTE_CRC_HI);
                r_status      <= '0;
                r_slave_index <= '0;
                r_reg_first   <= '0;
                r_reg_second  <= '0;
            end else begin
                r_kind        <= mrpm_pkg::C_KIND_OUTCOME;
                r_tx_byte     <= '0;
                r_last        <= 1'b0;
                r_status      <= i_cmd.status;
                r_slave_index <= i_cmd.slave_idx;
                r_reg_first   <= i_cmd.reg_first;
                r_reg_second  <= i_cmd.reg_second;
            end
        end
    end

    assign o_empty       = ~r_out_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_last        = r_last;
    assign o_status      = r_status;
    assign o_slave_index = r_slave_index;
    assign o_reg_first   = r_reg_first;
    assign o_reg_second  = r_reg_second;

endmodule

`default_nettype wire

// ----- sv/modbus_rtu_poll_master_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master_unit
// Modbus RTU master polling up to three slaves with read-holding-registers.
//
// Input queue (push/full): op start emits the 8-byte request for the current
// slave, op rx stores one received byte, op end reports one outcome and
// advances to the next slave. Result queue (empty/pop): request bytes
// (kind 0, last on the eighth) or one outcome (kind 1) per end item.
// An item is taken every cycle while full is low. A start yields one request
// byte per cycle while the result side does not stall, as the back end runs
// the request CRC a byte per cycle; an end yields one outcome, a received
// byte yields nothing. Results pass the command queue, then the output
// register. The 4-entry command queue and the output register absorb
// result-side stalls; full rises when the queue is full. Reset restores the
// register defaults, slave index 0 and clears both queues. Registers sit on
// the APB port at byte address 4*i, with pready tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_poll_master_unit #(
    parameter int unsigned RX_BUFFER_BYTES = 64,
    parameter int unsigned SLAVE_COUNT     = 3
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire [1:0]                    i_op,
    input  wire [7:0]                    i_rx_byte,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_kind,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    output logic [1:0]                   o_slave_index,
    output logic [15:0]                  o_reg_first,
    output logic [15:0]                  o_reg_second,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [mrpm_pkg::C_ADDR_W-1:0] paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]  r_addr0, r_addr1, r_addr2;
    logic [15:0] r_start_reg, r_reg_count;
    logic        cfg_wr;
    mrpm_pkg::t_reg_idx reg_idx;

    mrpm_pkg::t_addr_arr poll_addr;
    mrpm_pkg::t_cmd      front_cmd, head_cmd;
    logic                cmd_push, cmd_full, cmd_valid, cmd_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = mrpm_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr0     <= mrpm_pkg::C_ADDR0_RST;
            r_addr1     <= mrpm_pkg::C_ADDR1_RST;
            r_addr2     <= mrpm_pkg::C_ADDR2_RST;
            r_start_reg <= mrpm_pkg::C_START_RST;
            r_reg_count <= mrpm_pkg::C_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                mrpm_pkg::REG_POLL_ADDR_0: r_addr0     <= pwdata[7:0];
                mrpm_pkg::REG_POLL_ADDR_1: r_addr1     <= pwdata[7:0];
                mrpm_pkg::REG_POLL_ADDR_2: r_addr2     <= pwdata[7:0];
                mrpm_pkg::REG_START_REG:   r_start_reg <= pwdata[15:0];
                mrpm_pkg::REG_REG_COUNT:   r_reg_count <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mrpm_pkg::REG_POLL_ADDR_0: prdata = {24'h0, r_addr0};
            mrpm_pkg::REG_POLL_ADDR_1: prdata = {24'h0, r_addr1};
            mrpm_pkg::REG_POLL_ADDR_2: prdata = {24'h0, r_addr2};
            mrpm_pkg::REG_START_REG:   prdata = {16'h0, r_start_reg};
            mrpm_pkg::REG_REG_COUNT:   prdata = {16'h0, r_reg_count};
            default:                   prdata = '0;
        endcase
    end

    assign poll_addr = {r_addr2, r_addr1, r_addr0};
    assign full      = cmd_full;

    mrpm_front #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES),
        .SLAVE_COUNT     (SLAVE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .i_poll_addr  (poll_addr),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (front_cmd)
    );

    mrpm_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    mrpm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (cmd_pop),
        .i_start_reg   (r_start_reg),
        .i_reg_count   (r_reg_count),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_status      (o_status),
        .o_slave_index (o_slave_index),
        .o_reg_first   (o_reg_first),
        .o_reg_second  (o_reg_second)
    );

endmodule

`default_nettype wire

// ----- tb/modbus_rtu_poll_master_unit_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master_unit_tb
// Self-checking bench for the Modbus RTU poll master. A short script covers
// reset defaults, byte extremes, every op and each outcome code, then random
// response frames run under several register settings. Every result transfer
// is checked field by field against an in-bench model of the request builder,
// receive CRC and outcome logic, with random gaps on both queue sides.
// ----------------------------------------------------------------------------
module modbus_rtu_poll_master_unit_tb;

    localparam int unsigned RX_BUFFER_BYTES = 64;
    localparam int unsigned SLAVE_COUNT     = 3;
    localparam int          QUIET_LIMIT     = 1000;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          PHASES          = 8;
    localparam int          PHASE_ITEMS     = 32;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    localparam mrpm_pkg::t_op     OP_START     = mrpm_pkg::OP_START;
    localparam mrpm_pkg::t_op     OP_RX        = mrpm_pkg::OP_RX;
    localparam mrpm_pkg::t_op     OP_END       = mrpm_pkg::OP_END;
    localparam mrpm_pkg::t_status ST_OK        = mrpm_pkg::ST_OK;
    localparam mrpm_pkg::t_status ST_SHORT     = mrpm_pkg::ST_SHORT;
    localparam mrpm_pkg::t_status ST_ADDR_MISS = mrpm_pkg::ST_ADDR_MISS;
    localparam mrpm_pkg::t_status ST_CRC_MISS  = mrpm_pkg::ST_CRC_MISS;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_CRC_LO,
        FILL_CRC_HI,
        FILL_CRC_LO_BAD
    } t_fill;

    typedef struct packed {
        logic              kind;
        logic [7:0]        tx_byte;
        logic              last;
        mrpm_pkg::t_status status;
        logic [1:0]        slave;
        logic [15:0]       reg_first;
        logic [15:0]       reg_second;
    } t_poll_result;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        data;
        t_fill             fill;
        logic              pin;
        mrpm_pkg::t_status stat;
        logic [1:0]        slave;
        logic [15:0]       reg_first;
        logic [15:0]       reg_second;
    } t_script_row;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    logic [1:0]                    i_op      = 2'd0;
    logic [7:0]                    i_rx_byte = 8'h00;
    logic                          empty;
    logic                          pop       = 1'b0;
    logic                          o_kind;
    logic [7:0]                    o_tx_byte;
    logic                          o_last;
    logic [1:0]                    o_status;
    logic [1:0]                    o_slave_index;
    logic [15:0]                   o_reg_first;
    logic [15:0]                   o_reg_second;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [mrpm_pkg::C_ADDR_W-1:0] paddr     = '0;
    logic [31:0]                   pwdata    = 32'h0;
    logic [31:0]                   prdata;
    logic                          pready;

    // typed expectation travelling with a scripted item
    logic                pin_en    = 1'b0;
    t_poll_result        pin_res   = '0;

    logic                tx_tight  = 1'b0;
    logic                rx_tight  = 1'b0;

    logic [7:0]  cfg_addr [3] = '{mrpm_pkg::C_ADDR0_RST, mrpm_pkg::C_ADDR1_RST,
                                  mrpm_pkg::C_ADDR2_RST};
    logic [15:0] cfg_start    = mrpm_pkg::C_START_RST;
    logic [15:0] cfg_count    = mrpm_pkg::C_COUNT_RST;

    logic [1:0]  poll_idx       = 2'd0;
    int          rx_held        = 0;
    logic [7:0]  first_byte     = 8'h00;
    logic [7:0]  data_bytes [4] = '{default: 8'h00};
    logic [15:0] crc_acc        = mrpm_pkg::C_CRC_INIT;
    logic [7:0]  tail [2]       = '{default: 8'h00};

    t_poll_result expected_results [$];
    t_script_row  script [25];

    logic [1:0]  gen_slave    = 2'd0;
    int          items_sent   = 0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          tx_count     = 0;
    int          outcome_hits [4] = '{default: 0};

    modbus_rtu_poll_master_unit #(
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
        .SLAVE_COUNT    (SLAVE_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_slave_index(o_slave_index),
        .o_reg_first  (o_reg_first),
        .o_reg_second (o_reg_second),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? mrpm_pkg::C_CRC_POLY : 16'h0000);
        return r;
    endfunction

    function automatic void predict_step(logic [1:0] op, logic [7:0] b);
        logic [7:0]   req [8];
        logic [15:0]  crc;
        t_poll_result r;
        int           i;
        case (op)
            OP_START: begin
                rx_held    = 0;
                first_byte = 8'h00;
                data_bytes = '{default: 8'h00};
                tail       = '{default: 8'h00};
                crc_acc    = mrpm_pkg::C_CRC_INIT;
                req[0] = cfg_addr[poll_idx];
                req[1] = mrpm_pkg::C_FUNC_READ_REG;
                req[2] = cfg_start[15:8];
                req[3] = cfg_start[7:0];
                req[4] = cfg_count[15:8];
                req[5] = cfg_count[7:0];
                crc = mrpm_pkg::C_CRC_INIT;
                for (i = 0; i < 6; i++) crc = crc16_update(crc, req[i]);
                req[6] = crc[7:0];
                req[7] = crc[15:8];
                for (i = 0; i < 8; i++) begin
                    r = '0;
                    r.kind    = mrpm_pkg::C_KIND_TX;
                    r.tx_byte = req[i];
                    r.last    = (i == 7);
                    expected_results.push_back(r);
                end
            end
            OP_RX: begin
                if (rx_held < RX_BUFFER_BYTES) begin
                    if (rx_held >= 2) crc_acc = crc16_update(crc_acc, tail[0]);
                    tail[0] = tail[1];
                    tail[1] = b;
                    if (rx_held == 0) first_byte = b;
                    if (rx_held >= 3 && rx_held <= 6) data_bytes[rx_held - 3] = b;
                    rx_held++;
                end
            end
            OP_END: begin
                r = '0;
                r.kind  = mrpm_pkg::C_KIND_OUTCOME;
                r.slave = poll_idx;
                if (rx_held < mrpm_pkg::C_MIN_RESP) begin
                    r.status = ST_SHORT;
                end else if (first_byte != cfg_addr[poll_idx]) begin
                    r.status = ST_ADDR_MISS;
                end else if ({tail[1], tail[0]} != crc_acc) begin
                    r.status = ST_CRC_MISS;
                end else begin
                    r.status     = ST_OK;
                    r.reg_first  = {data_bytes[0], data_bytes[1]};
                    r.reg_second = {data_bytes[2], data_bytes[3]};
                end
                expected_results.push_back(r);
                poll_idx = (poll_idx == SLAVE_COUNT - 1) ? 2'd0 : poll_idx + 2'd1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_poll_result want;
        if (push && !full) begin
            predict_step(i_op, i_rx_byte);
            if (pin_en) expected_results[expected_results.size() - 1] = pin_res;
        end
        if (pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("tx_byte", want.tx_byte, o_tx_byte);
                check_field("last", want.last, o_last);
                check_field("status", want.status, o_status);
                check_field("slave_index", want.slave, o_slave_index);
                check_field("reg_first", want.reg_first, o_reg_first);
                check_field("reg_second", want.reg_second, o_reg_second);
                if (want.kind == mrpm_pkg::C_KIND_OUTCOME) outcome_hits[want.status]++;
                else tx_count++;
            end
        end
        if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : result_drain
        int stall;
        wait (i_rst_n);
        forever begin
            stall = rx_tight ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] value,
                             logic pin = 1'b0, t_poll_result pinned = '0);
        int gap;
        gap = tx_tight ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_op      <= op;
        i_rx_byte <= value;
        pin_en    <= pin;
        pin_res   <= pinned;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
        if (op == OP_END) gen_slave = (gen_slave == SLAVE_COUNT - 1) ? 2'd0 : gen_slave + 2'd1;
    endtask

    task automatic drain_and_hold();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(mrpm_pkg::t_reg_idx idx, logic [15:0] value);
        logic [15:0] mask;
        mask  = (idx <= mrpm_pkg::REG_POLL_ADDR_2) ? 16'h00FF : 16'hFFFF;
        value = value & mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mrpm_pkg::C_ADDR_W'(4 * int'(idx));
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            mrpm_pkg::REG_POLL_ADDR_0: cfg_addr[0] = value[7:0];
            mrpm_pkg::REG_POLL_ADDR_1: cfg_addr[1] = value[7:0];
            mrpm_pkg::REG_POLL_ADDR_2: cfg_addr[2] = value[7:0];
            mrpm_pkg::REG_START_REG:   cfg_start   = value;
            mrpm_pkg::REG_REG_COUNT:   cfg_count   = value;
            default: begin
            end
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata[15:0] & mask) !== value) begin
            $error("%s: expected %0h, got %0h", idx.name(), value, prdata[15:0] & mask);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one poll: optional start, a response frame (often damaged or odd-sized), end
    task automatic run_exchange();
        logic [7:0]  frame [$];
        logic [15:0] crc;
        int          pick;
        int          n;
        int          pos;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        if (pick >= 14) send_item(OP_START, 8'($urandom));
        pick = $urandom_range(0, 19);
        if (pick < 12) n = 4;
        else if (pick < 15) n = $urandom_range(0, 3);
        else if (pick < 18) n = $urandom_range(5, 24);
        else if (pick == 18) n = RX_BUFFER_BYTES - 5;
        else n = $urandom_range(RX_BUFFER_BYTES - 4, RX_BUFFER_BYTES + 6);
        frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_addr[gen_slave]);
        frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                    : mrpm_pkg::C_FUNC_READ_REG);
        frame.push_back(8'(n));
        repeat (n) frame.push_back(8'($urandom));
        crc = mrpm_pkg::C_CRC_INIT;
        foreach (frame[j]) crc = crc16_update(crc, frame[j]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        case ($urandom_range(0, 9))
            0: begin
                pos = $urandom_range(0, frame.size() - 1);
                frame[pos] = frame[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
            1: begin
                pos = $urandom_range(0, frame.size() - 1);
                while (frame.size() > pos) void'(frame.pop_back());
            end
            2: frame.push_back(8'($urandom));
            default: begin
            end
        endcase
        foreach (frame[j]) begin
            if ($urandom_range(0, 29) == 0) send_item(OP_UNUSED, 8'($urandom));
            send_item(OP_RX, frame[j]);
        end
        send_item(OP_END, 8'($urandom));
        if ($urandom_range(0, 7) == 0) send_item(OP_END, 8'($urandom));
    endtask

    initial begin : stimulus
        t_poll_result pres;
        logic [15:0]  frame_crc;
        logic [7:0]   byte_val;
        logic [15:0]  setting [5];
        logic [15:0]  same_addr;
        int           target;

        script = '{
            '{OP_END,    8'h00, FILL_NONE,       1'b1, ST_SHORT,     2'd0, 16'h0000, 16'h0000},
            '{OP_UNUSED, 8'hFF, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_START,  8'hFF, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h02, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h03, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h04, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'hFF, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'hFF, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_CRC_LO,     1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_CRC_HI,     1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_END,    8'h00, FILL_NONE,       1'b1, ST_OK,        2'd1, 16'hFFFF, 16'h0000},
            '{OP_END,    8'h00, FILL_NONE,       1'b1, ST_ADDR_MISS, 2'd2, 16'h0000, 16'h0000},
            '{OP_START,  8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h01, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h03, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h04, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_NONE,       1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_CRC_LO_BAD, 1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_RX,     8'h00, FILL_CRC_HI,     1'b0, ST_OK,        2'd0, 16'h0000, 16'h0000},
            '{OP_END,    8'h00, FILL_NONE,       1'b1, ST_CRC_MISS,  2'd0, 16'h0000, 16'h0000}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        frame_crc = mrpm_pkg::C_CRC_INIT;
        foreach (script[r]) begin
            byte_val = script[r].data;
            case (script[r].fill)
                FILL_CRC_LO:     byte_val = frame_crc[7:0];
                FILL_CRC_HI:     byte_val = frame_crc[15:8];
                FILL_CRC_LO_BAD: byte_val = frame_crc[7:0] ^ 8'h01;
                default: begin
                end
            endcase
            if (script[r].op == OP_START) frame_crc = mrpm_pkg::C_CRC_INIT;
            else if (script[r].op == OP_RX && script[r].fill == FILL_NONE)
                frame_crc = crc16_update(frame_crc, byte_val);
            pres = '0;
            pres.kind       = mrpm_pkg::C_KIND_OUTCOME;
            pres.status     = script[r].stat;
            pres.slave      = script[r].slave;
            pres.reg_first  = script[r].reg_first;
            pres.reg_second = script[r].reg_second;
            send_item(script[r].op, byte_val, script[r].pin, pres);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_and_hold();
            case (phase)
                0: setting = '{16'h0000, 16'h00FF, 16'h007F, 16'hFFFF, 16'h0000};
                1: setting = '{16'h00FF, 16'h0000, 16'h0080, 16'h0000, 16'hFFFF};
                2: begin
                    same_addr = 16'($urandom_range(0, 255));
                    setting = '{same_addr, same_addr, same_addr, 16'($urandom),
                                mrpm_pkg::C_COUNT_RST};
                end
                default: foreach (setting[k]) setting[k] = 16'($urandom);
            endcase
            foreach (setting[k]) reg_write(mrpm_pkg::t_reg_idx'(k), setting[k]);
            tx_tight = (phase == 3) || ($urandom_range(0, 3) == 0);
            rx_tight = (phase == 3) || ($urandom_range(0, 3) == 0);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_exchange();
        end
        drain_and_hold();

        $display("tb: %0d input items over %0d register settings, %0d request bytes checked",
                 items_sent, PHASES + 1, tx_count);
        $display("tb: outcomes ok %0d, short %0d, address miss %0d, crc miss %0d",
                 outcome_hits[ST_OK], outcome_hits[ST_SHORT],
                 outcome_hits[ST_ADDR_MISS], outcome_hits[ST_CRC_MISS]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
